// ----- hdl/ssds_pkg.sv -----
package ssds_pkg;

  // fixed field widths
  localparam int unsigned FUNC_W  = 32;
  localparam int unsigned IP_W    = 64;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned PLEN_W  = 6;

  // stream widths, rounded up to whole bytes
  localparam int unsigned IN_DW  = 168;
  localparam int unsigned OUT_DW = 240;

  // input selector
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_CHG_IP,
    OP_SAMPLE
  } op_e;

  // result kind
  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_FRAME,
    KIND_ERROR
  } kind_e;

  // error codes
  typedef enum logic [1:0] {
    ERR_OVERFLOW,
    ERR_UNDERFLOW,
    ERR_BAD_INDEX
  } err_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FRAME
  } state_e;

  // input beat payload, last declared field in the lowest bits
  typedef struct packed {
    logic [2:0]         pad;
    logic [STAMP_W-1:0] hit_count;
    logic [STAMP_W-1:0] tick_stamp;
    logic [IDX_W-1:0]   depth_from_top;
    logic [IP_W-1:0]    new_ip;
    logic [FUNC_W-1:0]  func_id;
  } in_data_t;

  // output beat payload, last declared field in the lowest bits
  typedef struct packed {
    logic [6:0]         pad;
    logic [IP_W-1:0]    frame_ip;
    logic [FUNC_W-1:0]  frame_func;
    logic [STAMP_W-1:0] sample_count;
    logic [STAMP_W-1:0] sample_ticks;
    logic [IP_W-1:0]    changed_ip;
    logic               ip_changed;
    logic [PLEN_W-1:0]  prefix_length;
    logic [1:0]         error_code;
  } out_data_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic push;
    logic pop;
    logic write_ip;
    logic load_hdr;
    logic load_frame;
    logic load_err;
    err_e err_code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic chg_bad;
    logic smp_empty;
    logic last_frame;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/ssds_ctrl.sv -----
module ssds_ctrl import ssds_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  output logic    s_tready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (status_i.op)
          OP_PUSH: begin
            if (!status_i.full) begin
              cmd_o.push = 1'b1;
              state_d    = ST_IDLE;
            end else if (status_i.out_free) begin
              cmd_o.load_err = 1'b1;
              cmd_o.err_code = ERR_OVERFLOW;
              state_d        = ST_IDLE;
            end
          end
          OP_POP: begin
            if (!status_i.empty) begin
              cmd_o.pop = 1'b1;
              state_d   = ST_IDLE;
            end else if (status_i.out_free) begin
              cmd_o.load_err = 1'b1;
              cmd_o.err_code = ERR_UNDERFLOW;
              state_d        = ST_IDLE;
            end
          end
          OP_CHG_IP: begin
            if (!status_i.chg_bad) begin
              cmd_o.write_ip = 1'b1;
              state_d        = ST_IDLE;
            end else if (status_i.out_free) begin
              cmd_o.load_err = 1'b1;
              cmd_o.err_code = ERR_BAD_INDEX;
              state_d        = ST_IDLE;
            end
          end
          OP_SAMPLE: begin
            if (status_i.out_free) begin
              cmd_o.load_hdr = 1'b1;
              state_d        = status_i.smp_empty ? ST_IDLE : ST_FRAME;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_FRAME: begin
        if (status_i.out_free) begin
          cmd_o.load_frame = 1'b1;
          if (status_i.last_frame) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/ssds_dpath.sv -----
module ssds_dpath import ssds_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IN_DW-1:0]  s_tdata_i,
  input  logic [1:0]        s_tuser_i,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [OUT_DW-1:0] m_tdata_o,
  output logic [1:0]        m_tuser_o,
  output logic              m_tlast_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned SW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned XW = (SW > IDX_W) ? SW : IDX_W;

  in_data_t in_data;
  assign in_data = in_data_t'(s_tdata_i);

  // latched item
  op_e                op_q;
  logic [FUNC_W-1:0]  func_q;
  logic [IP_W-1:0]    newip_q;
  logic [IDX_W-1:0]   idx_q;
  logic [STAMP_W-1:0] tick_q;
  logic [STAMP_W-1:0] hit_q;

  // stack state
  logic [SW-1:0] size_q, size_d;
  logic [SW-1:0] mp_q, mp_d;
  logic          chg_q, chg_d;
  logic [AW-1:0] ptr_q, ptr_d;

  // frame stores
  logic [FUNC_W-1:0] mem_func [STACK_DEPTH];
  logic [IP_W-1:0]   mem_ip   [STACK_DEPTH];
  logic [FUNC_W-1:0] rd_func_q;
  logic [IP_W-1:0]   rd_ip_q;

  // output register
  logic      out_valid_q;
  out_data_t out_data_q, out_data_d;
  kind_e     out_kind_q, out_kind_d;
  logic      out_last_q, out_last_d;
  logic      out_load;

  // index arithmetic
  logic [XW-1:0] size_x, mp_x, idx_x, diff_x, in_idx_x, pos_x;
  logic [AW-1:0] acc_addr;
  logic          chg_top, ip_diff, hdr_chg, out_free;

  assign size_x   = XW'(size_q);
  assign mp_x     = XW'(mp_q);
  assign idx_x    = XW'(idx_q);
  assign diff_x   = size_x - idx_x;
  assign in_idx_x = XW'(in_data.depth_from_top);
  assign pos_x    = size_x - in_idx_x - XW'(1);
  assign acc_addr = (op_e'(s_tuser_i) == OP_SAMPLE) ? AW'(mp_q - SW'(1)) : pos_x[AW-1:0];
  assign chg_top  = (diff_x == mp_x);
  assign ip_diff  = (rd_ip_q != newip_q);
  assign hdr_chg  = chg_q && (mp_q != '0);
  assign out_free = !out_valid_q || m_tready_i;
  assign out_load = cmd_i.load_hdr || cmd_i.load_frame || cmd_i.load_err;

  // status towards the controller
  always_comb begin
    status_o.op         = op_q;
    status_o.full       = (size_q == SW'(STACK_DEPTH));
    status_o.empty      = (size_q == '0);
    status_o.chg_bad    = (idx_x >= size_x) || (diff_x < mp_x);
    status_o.smp_empty  = (size_q == mp_q);
    status_o.last_frame = ((SW'(ptr_q) + SW'(1)) == size_q);
    status_o.out_free   = out_free;
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= op_e'(s_tuser_i);
      func_q  <= in_data.func_id;
      newip_q <= in_data.new_ip;
      idx_q   <= in_data.depth_from_top;
      tick_q  <= in_data.tick_stamp;
      hit_q   <= in_data.hit_count;
    end
  end

  // stack size, prefix, changed flag and read pointer
  always_comb begin
    size_d = size_q;
    mp_d   = mp_q;
    chg_d  = chg_q;
    ptr_d  = ptr_q;
    if (cmd_i.push) begin
      size_d = size_q + SW'(1);
    end
    if (cmd_i.pop) begin
      size_d = size_q - SW'(1);
      if ((size_q - SW'(1)) < mp_q) begin
        mp_d  = size_q - SW'(1);
        chg_d = 1'b0;
      end
    end
    if (cmd_i.write_ip && chg_top && ip_diff) begin
      chg_d = 1'b1;
    end
    if (cmd_i.load_hdr) begin
      mp_d  = size_q;
      chg_d = 1'b0;
    end
    priority if (cmd_i.accept) begin
      ptr_d = acc_addr;
    end else if (cmd_i.load_hdr) begin
      ptr_d = mp_q[AW-1:0];
    end else if (cmd_i.load_frame) begin
      ptr_d = ptr_q + AW'(1);
    end else begin
      ptr_d = ptr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
      mp_q   <= '0;
      chg_q  <= 1'b0;
      ptr_q  <= '0;
    end else begin
      size_q <= size_d;
      mp_q   <= mp_d;
      chg_q  <= chg_d;
      ptr_q  <= ptr_d;
    end
  end

  // frame stores, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_func[size_q[AW-1:0]] <= func_q;
      mem_ip[size_q[AW-1:0]]   <= '0;
    end else if (cmd_i.write_ip) begin
      mem_ip[ptr_q] <= newip_q;
    end
    rd_func_q <= mem_func[ptr_d];
    rd_ip_q   <= mem_ip[ptr_d];
  end

  // result beat assembly
  always_comb begin
    out_data_d = '0;
    out_kind_d = KIND_ERROR;
    out_last_d = 1'b0;
    priority if (cmd_i.load_hdr) begin
      out_kind_d                 = KIND_HEADER;
      out_data_d.prefix_length   = PLEN_W'(mp_q);
      out_data_d.ip_changed      = hdr_chg;
      out_data_d.changed_ip      = hdr_chg ? rd_ip_q : '0;
      out_data_d.sample_ticks    = tick_q;
      out_data_d.sample_count    = hit_q;
      out_last_d                 = (size_q == mp_q);
    end else if (cmd_i.load_frame) begin
      out_kind_d            = KIND_FRAME;
      out_data_d.frame_func = rd_func_q;
      out_data_d.frame_ip   = rd_ip_q;
      out_last_d            = status_o.last_frame;
    end else begin
      out_data_d.error_code = cmd_i.err_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
      out_kind_q <= out_kind_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;

endmodule

// ----- hdl/shadow_stack_delta_sampler.sv -----
// channel   | direction | tdata (low bit up)                                    | tuser | tlast
// s_axis    | in        | func_id, new_ip, depth_from_top, tick_stamp, hit_count | op    | -
// m_axis    | out       | error_code, prefix_length, ip_changed, changed_ip,     | kind  | last
//           |           | sample_ticks, sample_count, frame_func, frame_ip       |       |
//
// push, pop and change ip are accepted, then executed against the registered frame store
// read. a sample loads its header in the execute state that follows accept, then one frame
// a cycle from the single read port while the output is free, for each frame above the prefix.
// reset clears stack size, prefix and the changed flag; the frame stores are not cleared.
// a stalled output holds the controller in place when a result is due; one item is in flight at a time.
module shadow_stack_delta_sampler import ssds_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // func_id, new_ip, depth_from_top, tick_stamp, hit_count
  input  logic [IN_DW-1:0]  s_axis_tdata,
  // operation
  input  logic [1:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // error_code, prefix_length, ip_changed, changed_ip, sample_ticks, sample_count,
  // frame_func, frame_ip
  output logic [OUT_DW-1:0] m_axis_tdata,
  // kind
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  ssds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // stack, frame stores and output register
  ssds_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .cmd_i      (cmd),
    .status_o   (status),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

  // at most one result beat loaded a cycle
  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_hdr, cmd.load_frame, cmd.load_err}))
    else $error("several result loads in one cycle");

  // a result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_hdr || cmd.load_frame || cmd.load_err) |-> status.out_free)
    else $error("result loaded over a waiting beat");

  // no second beat taken right after an accepted one
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in work");

  // stack edits never coincide with result loads
  a_edit_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.push || cmd.pop || cmd.write_ip) |-> !(cmd.load_hdr || cmd.load_frame || cmd.load_err))
    else $error("stack edit together with a result");

endmodule
